[sv/segrect_pkg.sv]
// ----------------------------------------------------------------------------
// Segment rectangle intersection package
// Shared constants and register map for the segment versus rectangle test.
// ----------------------------------------------------------------------------
package segrect_pkg;

   // Default coordinate width in bits (signed Q8.8 at the default).
   localparam int COORD_WIDTH_DEFAULT = 16;

   // The value 1.0 in Q8.8, used as reset for the right and top edges.
   localparam int COORD_ONE = 256;

   // Width of the register port.
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   typedef enum logic [1:0] {
      REG_LEFT_X   = 2'd0,
      REG_RIGHT_X  = 2'd1,
      REG_BOTTOM_Y = 2'd2,
      REG_TOP_Y    = 2'd3
   } csr_index_type;

endpackage

[sv/segment_rectangle_intersection_core.sv]
// ----------------------------------------------------------------------------
// Segment rectangle intersection core
// Reports whether a 2D segment touches an axis-aligned rectangle.
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid / req_stall  req_start_x/y, req_end_x/y
//   rsp       out         rsp_valid / rsp_stall  rsp_hit
//   csr       in          psel/penable/pready    rectangle edges at 4*index
//
// One request is accepted per cycle while req_stall is low, and its response is
// registered through four register stages: input (loaded at the accepting edge),
// differences, products, and the final compare into the response register.
// Reset is synchronous; it empties the pipeline and loads the unit rectangle.
// A stalled response holds the pipeline, and bubbles close up behind it.
// ----------------------------------------------------------------------------
module segment_rectangle_intersection_core
   import segrect_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     prdata,
   output logic                          pready
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int PW = 2 * DW;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x1;
      logic signed [COORD_WIDTH-1:0] y1;
      logic signed [COORD_WIDTH-1:0] x2;
      logic signed [COORD_WIDTH-1:0] y2;
   } seg_type;

   typedef struct packed {
      logic inside_any;
      logic vert;
      logic vert_hit;
      logic horiz;
      logic horiz_hit;
      logic cross_l;
      logic cross_r;
      logic cross_b;
      logic cross_t;
   } flags_type;

   typedef struct packed {
      flags_type          flags;
      logic signed [DW-1:0] ex;
      logic signed [DW-1:0] ey;
      logic signed [DW-1:0] fx;
      logic signed [DW-1:0] fy;
      logic signed [DW-1:0] dbot;
      logic signed [DW-1:0] dtop;
      logic signed [DW-1:0] dlft;
      logic signed [DW-1:0] drgt;
   } diff_type;

   typedef struct packed {
      flags_type          flags;
      logic signed [PW-1:0] bot_ex;
      logic signed [PW-1:0] top_ex;
      logic signed [PW-1:0] ey_l;
      logic signed [PW-1:0] ey_r;
      logic signed [PW-1:0] l_fy;
      logic signed [PW-1:0] r_fy;
      logic signed [PW-1:0] fx_b;
      logic signed [PW-1:0] fx_t;
   } prod_type;

   logic signed [COORD_WIDTH-1:0] left_x_ff, right_x_ff, bottom_y_ff, top_y_ff;
   logic signed [COORD_WIDTH-1:0] wdata;
   logic                          csr_write;
   csr_index_type                 csr_index;

   logic     va_ff, vb_ff, vc_ff, rsp_valid_ff, rsp_hit_ff;
   seg_type  a_ff;
   diff_type b_ff, b_in;
   prod_type c_ff, c_in;
   logic     rsp_hit_in;
   logic     en_a, en_b, en_c, en_out;

   // Configuration registers.
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign wdata     = COORD_WIDTH'(pwdata);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff   <= '0;
         right_x_ff  <= COORD_WIDTH'(COORD_ONE);
         bottom_y_ff <= '0;
         top_y_ff    <= COORD_WIDTH'(COORD_ONE);
      end else if (csr_write) begin
         case (csr_index)
            REG_LEFT_X:   left_x_ff   <= wdata;
            REG_RIGHT_X:  right_x_ff  <= wdata;
            REG_BOTTOM_Y: bottom_y_ff <= wdata;
            REG_TOP_Y:    top_y_ff    <= wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LEFT_X:   prdata = CSR_DATA_WIDTH'(left_x_ff);
         REG_RIGHT_X:  prdata = CSR_DATA_WIDTH'(right_x_ff);
         REG_BOTTOM_Y: prdata = CSR_DATA_WIDTH'(bottom_y_ff);
         REG_TOP_Y:    prdata = CSR_DATA_WIDTH'(top_y_ff);
         default:      prdata = '0;
      endcase
   end

   // Pipeline advance: a stage loads when it is empty or its content moves on.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_c      = !vc_ff || en_out;
   assign en_b      = !vb_ff || en_c;
   assign en_a      = !va_ff || en_b;
   assign req_stall = !en_a;

   // Stage B: differences, direction normalization and simple compares.
   always_comb begin
      logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2;
      logic signed [DW-1:0]          dx, dy, nx, ny;
      x1 = a_ff.x1;
      y1 = a_ff.y1;
      x2 = a_ff.x2;
      y2 = a_ff.y2;

      b_in.flags.inside_any =
         (left_x_ff <= x1 && x1 <= right_x_ff && bottom_y_ff <= y1 && y1 <= top_y_ff) ||
         (left_x_ff <= x2 && x2 <= right_x_ff && bottom_y_ff <= y2 && y2 <= top_y_ff);
      b_in.flags.vert      = (x1 == x2);
      b_in.flags.vert_hit  = left_x_ff <= x1 && x1 <= right_x_ff &&
         ((y1 < bottom_y_ff && top_y_ff < y2) || (y2 < bottom_y_ff && top_y_ff < y1));
      b_in.flags.horiz     = (y1 == y2);
      b_in.flags.horiz_hit = bottom_y_ff <= y1 && y1 <= top_y_ff &&
         ((x1 < left_x_ff && right_x_ff < x2) || (x2 < left_x_ff && right_x_ff < x1));
      b_in.flags.cross_l   = (x1 < left_x_ff && left_x_ff < x2) ||
                             (x2 < left_x_ff && left_x_ff < x1);
      b_in.flags.cross_r   = (x1 < right_x_ff && right_x_ff < x2) ||
                             (x2 < right_x_ff && right_x_ff < x1);
      b_in.flags.cross_b   = (y1 < bottom_y_ff && bottom_y_ff < y2) ||
                             (y2 < bottom_y_ff && bottom_y_ff < y1);
      b_in.flags.cross_t   = (y1 < top_y_ff && top_y_ff < y2) ||
                             (y2 < top_y_ff && top_y_ff < y1);

      dx = DW'(x2) - DW'(x1);
      dy = DW'(y2) - DW'(y1);
      // The side edge test wants a direction with positive x.
      nx = dx[DW-1] ? -dx : dx;
      ny = dx[DW-1] ? -dy : dy;
      b_in.ex = nx;
      b_in.ey = ny;
      // The bottom and top edge test wants a direction with positive y.
      b_in.fx = ny[DW-1] ? -nx : nx;
      b_in.fy = ny[DW-1] ? -ny : ny;

      b_in.dbot = DW'(bottom_y_ff) - DW'(y1);
      b_in.dtop = DW'(top_y_ff) - DW'(y1);
      b_in.dlft = DW'(left_x_ff) - DW'(x1);
      b_in.drgt = DW'(right_x_ff) - DW'(x1);
   end

   // Stage C: exact cross products.
   always_comb begin
      c_in.flags  = b_ff.flags;
      c_in.bot_ex = PW'(b_ff.dbot) * PW'(b_ff.ex);
      c_in.top_ex = PW'(b_ff.dtop) * PW'(b_ff.ex);
      c_in.ey_l   = PW'(b_ff.ey) * PW'(b_ff.dlft);
      c_in.ey_r   = PW'(b_ff.ey) * PW'(b_ff.drgt);
      c_in.l_fy   = PW'(b_ff.dlft) * PW'(b_ff.fy);
      c_in.r_fy   = PW'(b_ff.drgt) * PW'(b_ff.fy);
      c_in.fx_b   = PW'(b_ff.fx) * PW'(b_ff.dbot);
      c_in.fx_t   = PW'(b_ff.fx) * PW'(b_ff.dtop);
   end

   // Output stage: range checks on the products and the final decision.
   always_comb begin
      logic side_l, side_r, flat_b, flat_t;
      side_l = c_ff.bot_ex <= c_ff.ey_l && c_ff.ey_l <= c_ff.top_ex;
      side_r = c_ff.bot_ex <= c_ff.ey_r && c_ff.ey_r <= c_ff.top_ex;
      flat_b = c_ff.l_fy <= c_ff.fx_b && c_ff.fx_b <= c_ff.r_fy;
      flat_t = c_ff.l_fy <= c_ff.fx_t && c_ff.fx_t <= c_ff.r_fy;
      if (c_ff.flags.inside_any) begin
         rsp_hit_in = 1'b1;
      end else if (c_ff.flags.vert) begin
         rsp_hit_in = c_ff.flags.vert_hit;
      end else if ((c_ff.flags.cross_l && side_l) || (c_ff.flags.cross_r && side_r)) begin
         rsp_hit_in = 1'b1;
      end else if (c_ff.flags.horiz) begin
         rsp_hit_in = c_ff.flags.horiz_hit;
      end else begin
         rsp_hit_in = (c_ff.flags.cross_b && flat_b) || (c_ff.flags.cross_t && flat_t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= req_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= vc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a && req_valid) begin
         a_ff.x1 <= req_start_x;
         a_ff.y1 <= req_start_y;
         a_ff.x2 <= req_end_x;
         a_ff.y2 <= req_end_y;
      end
      if (en_b && va_ff) begin
         b_ff <= b_in;
      end
      if (en_c && vb_ff) begin
         c_ff <= c_in;
      end
      if (en_out && vc_ff) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // Reset empties every stage.
   assert property (@(posedge clock) reset |=> !rsp_valid_ff && !va_ff && !vb_ff && !vc_ff)
      else $error("pipeline not empty after reset");

   // Requests are held off only when the whole pipeline is full behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> va_ff && vb_ff && vc_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled while the pipeline has room");

   // An endpoint inside the rectangle always yields a hit.
   assert property (@(posedge clock) disable iff (reset)
      en_out && vc_ff && c_ff.flags.inside_any |=> rsp_valid && rsp_hit)
      else $error("endpoint inside the rectangle did not report a hit");

endmodule

[tb/segrect_hit_check.sv]
// ----------------------------------------------------------------------------
// Segment rectangle hit checker
// Watches the request, response and register ports of the segment versus
// rectangle core. It keeps its own copy of the rectangle edges and predicts
// the hit flag of each accepted request with exact integer arithmetic.
// Each accepted response is compared with the oldest prediction. The checker
// reports the number of failures and the number of responses still due.
// ----------------------------------------------------------------------------
module segrect_hit_check
   import segrect_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,

   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,

   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   input  logic                          pready,

   output int                            mismatch_count,
   output int                            hits_outstanding
);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      logic      hit;
   } hit_expectation_type;

   longint              rect_left;
   longint              rect_right;
   longint              rect_bottom;
   longint              rect_top;
   hit_expectation_type pending_hits [$];
   hit_expectation_type expected;
   int                  mismatches;

   function automatic bit point_in_rect(longint x, longint y);
      return rect_left <= x && x <= rect_right && rect_bottom <= y && y <= rect_top;
   endfunction

   function automatic bit strictly_between(longint a, longint v, longint b);
      return (a < v && v < b) || (b < v && v < a);
   endfunction

   // The line through (x1, y1) with direction (dx, dy), dx > 0, meets x = edge
   // within the vertical span of the rectangle.
   function automatic bit crosses_side(longint x1, longint y1, longint dx, longint dy,
                                       longint edge_x);
      return (rect_bottom - y1) * dx <= dy * (edge_x - x1)
         && dy * (edge_x - x1) <= (rect_top - y1) * dx;
   endfunction

   // The line through (x1, y1) with direction (dx, dy), dy > 0, meets y = edge
   // within the horizontal span of the rectangle.
   function automatic bit crosses_flat(longint x1, longint y1, longint dx, longint dy,
                                       longint edge_y);
      return (rect_left - x1) * dy <= dx * (edge_y - y1)
         && dx * (edge_y - y1) <= (rect_right - x1) * dy;
   endfunction

   function automatic bit predict_hit(longint x1, longint y1, longint x2, longint y2);
      longint dx;
      longint dy;
      bit     hit;
      hit = 1'b0;
      if (point_in_rect(x1, y1) || point_in_rect(x2, y2)) begin
         hit = 1'b1;
      end else if (x1 == x2) begin
         hit = rect_left <= x1 && x1 <= rect_right
            && ((y1 < rect_bottom && rect_top < y2) || (y2 < rect_bottom && rect_top < y1));
      end else begin
         dx = x2 - x1;
         dy = y2 - y1;
         if (dx < 0) begin
            dx = -dx;
            dy = -dy;
         end
         if (strictly_between(x1, rect_left, x2) && crosses_side(x1, y1, dx, dy, rect_left)) begin
            hit = 1'b1;
         end else if (strictly_between(x1, rect_right, x2)
                      && crosses_side(x1, y1, dx, dy, rect_right)) begin
            hit = 1'b1;
         end else if (y1 == y2) begin
            hit = rect_bottom <= y1 && y1 <= rect_top
               && ((x1 < rect_left && rect_right < x2) || (x2 < rect_left && rect_right < x1));
         end else begin
            if (dy < 0) begin
               dx = -dx;
               dy = -dy;
            end
            if (strictly_between(y1, rect_bottom, y2)
                && crosses_flat(x1, y1, dx, dy, rect_bottom)) begin
               hit = 1'b1;
            end else if (strictly_between(y1, rect_top, y2)
                         && crosses_flat(x1, y1, dx, dy, rect_top)) begin
               hit = 1'b1;
            end
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rect_left   = 0;
         rect_right  = COORD_ONE;
         rect_bottom = 0;
         rect_top    = COORD_ONE;
         pending_hits.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected.sx  = req_start_x;
            expected.sy  = req_start_y;
            expected.ex  = req_end_x;
            expected.ey  = req_end_y;
            expected.hit = predict_hit(longint'(req_start_x), longint'(req_start_y),
                                       longint'(req_end_x), longint'(req_end_y));
            pending_hits.push_back(expected);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Response with no request waiting: hit %b", rsp_hit);
               end
            end else begin
               expected = pending_hits.pop_front();
               if (rsp_hit !== expected.hit) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Hit mismatch for segment (%0d,%0d)-(%0d,%0d): expected %b, got %b",
                              expected.sx, expected.sy, expected.ex, expected.ey,
                              expected.hit, rsp_hit);
                  end
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]))
               REG_LEFT_X:   rect_left   = longint'($signed(pwdata[COORD_WIDTH-1:0]));
               REG_RIGHT_X:  rect_right  = longint'($signed(pwdata[COORD_WIDTH-1:0]));
               REG_BOTTOM_Y: rect_bottom = longint'($signed(pwdata[COORD_WIDTH-1:0]));
               REG_TOP_Y:    rect_top    = longint'($signed(pwdata[COORD_WIDTH-1:0]));
               default: ;
            endcase
         end
      end
      mismatch_count   <= mismatches;
      hits_outstanding <= pending_hits.size();
   end

endmodule

[tb/segment_rectangle_intersection_core_tb.sv]
// ----------------------------------------------------------------------------
// Segment rectangle intersection core testbench
// Sends a short directed set of segments against the reset rectangle, then
// random segments in phases that change the rectangle and the idle and stall
// pressure on both channels. Random segments favor rectangle edges, corners,
// horizontal, vertical and degenerate cases. A separate checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module segment_rectangle_intersection_core_tb;
   import segrect_pkg::*;

   localparam int CW            = COORD_WIDTH_DEFAULT;
   localparam int COORD_MIN     = -(1 << (CW - 1));
   localparam int COORD_MAX     = (1 << (CW - 1)) - 1;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DIRECTED_ITEMS = 24;

   typedef logic signed [CW-1:0] coord_type;

   localparam int DIRECTED_SEGMENTS [DIRECTED_ITEMS][4] = '{
      '{-32768, -32768,  32767,  32767},
      '{ 32767, -32768, -32768,  32767},
      '{   128,    128,  32767, -32768},
      '{     0,      0,   -100,   -100},
      '{   256,    256,  32767,  32767},
      '{   128, -32768,    128,  32767},
      '{     0,   -500,      0,    500},
      '{   257,   -500,    257,    500},
      '{   128,   -500,    128,     -1},
      '{-32768,    128,  32767,    128},
      '{  -500,    256,    500,    256},
      '{  -500,     -1,    500,     -1},
      '{   300,    300,    300,    300},
      '{     5,      5,      5,      5},
      '{  -100,     50,    400,    200},
      '{   -10,    246,     10,    266},
      '{   -10,    247,     10,    267},
      '{   100,    -50,    150,    400},
      '{   300,    -50,    400,    400},
      '{ 32767,  32767, -32768, -32768},
      '{   128,  32767,    128, -32768},
      '{ 32767, -32768,  32767,  32767},
      '{-32768,  32767,  32767,  32767},
      '{   300,    100,   -300,    120}
   };

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   coord_type                 req_start_x = '0;
   coord_type                 req_start_y = '0;
   coord_type                 req_end_x   = '0;
   coord_type                 req_end_y   = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic                      rsp_hit;
   logic                      psel        = 1'b0;
   logic                      penable     = 1'b0;
   logic                      pwrite      = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr       = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata      = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int          mismatch_count;
   int          hits_outstanding;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int unsigned cycle_count = 0;
   int          rl;
   int          rr;
   int          rb;
   int          rt;
   int          a;
   int          b;
   int          px;
   int          py;
   int          dx;
   int          dy;
   int          shape;
   coord_type   sx;
   coord_type   sy;
   coord_type   ex;
   coord_type   ey;

   segment_rectangle_intersection_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_hit     (rsp_hit),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   segrect_hit_check i_hit_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .mismatch_count   (mismatch_count),
      .hits_outstanding (hits_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic coord_type clamp_coord(int v);
      if (v < COORD_MIN) begin
         return coord_type'(COORD_MIN);
      end else if (v > COORD_MAX) begin
         return coord_type'(COORD_MAX);
      end
      return coord_type'(v);
   endfunction

   // Picks a coordinate near the span [lo_edge, hi_edge]: on an edge, one step
   // off an edge, somewhere around the span, or anywhere in the full range.
   function automatic coord_type pick_coord(int edge_a, int edge_b);
      int lo;
      int hi;
      int span;
      int v;
      lo   = (edge_a < edge_b) ? edge_a : edge_b;
      hi   = (edge_a < edge_b) ? edge_b : edge_a;
      span = hi - lo + 64;
      case ($urandom_range(0, 9))
         0:       v = edge_a;
         1:       v = edge_b;
         2:       v = edge_a - 1;
         3:       v = edge_b + 1;
         4:       v = edge_a + 1;
         5:       v = edge_b - 1;
         6, 7:    v = lo - span + int'($urandom_range(0, 3 * span));
         default: v = COORD_MIN + int'($urandom_range(0, (1 << CW) - 1));
      endcase
      return clamp_coord(v);
   endfunction

   task automatic send_segment(coord_type x1, coord_type y1, coord_type x2, coord_type y2);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_start_x <= x1;
      req_start_y <= y1;
      req_end_x   <= x2;
      req_end_y   <= y2;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (hits_outstanding != 0);
   endtask

   task automatic write_edge(csr_index_type index, int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {16'($urandom()), 16'(value)};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      rl = 0;
      rr = COORD_ONE;
      rb = 0;
      rt = COORD_ONE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         send_segment(coord_type'(DIRECTED_SEGMENTS[i][0]),
                      coord_type'(DIRECTED_SEGMENTS[i][1]),
                      coord_type'(DIRECTED_SEGMENTS[i][2]),
                      coord_type'(DIRECTED_SEGMENTS[i][3]));
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_for_drain();
         case (p % 6)
            0: begin
               rl = int'($urandom_range(0, 4000)) - 2000;
               rr = rl + int'($urandom_range(0, 3000));
               rb = int'($urandom_range(0, 4000)) - 2000;
               rt = rb + int'($urandom_range(0, 3000));
            end
            1: begin
               rl = COORD_MIN;
               rr = COORD_MAX;
               rb = COORD_MIN;
               rt = COORD_MAX;
            end
            2: begin
               rl = int'($urandom_range(0, 2000)) - 1000;
               rr = rl;
               rb = int'($urandom_range(0, 2000)) - 1000;
               rt = rb;
            end
            3: begin
               // Inverted rectangle: right below left, sometimes top below bottom too.
               a  = int'($urandom_range(0, 4000)) - 2000;
               b  = a + 1 + int'($urandom_range(0, 3000));
               rl = b;
               rr = a;
               a  = int'($urandom_range(0, 4000)) - 2000;
               b  = a + int'($urandom_range(0, 3000));
               rb = $urandom_range(0, 1) ? b : a;
               rt = (rb == a) ? b : a;
            end
            4: begin
               rl = COORD_MIN;
               rr = COORD_MIN + int'($urandom_range(0, 20000));
               rb = COORD_MAX - int'($urandom_range(0, 20000));
               rt = COORD_MAX;
            end
            default: begin
               a  = COORD_MIN + int'($urandom_range(0, (1 << CW) - 1));
               b  = COORD_MIN + int'($urandom_range(0, (1 << CW) - 1));
               rl = (a < b) ? a : b;
               rr = (a < b) ? b : a;
               a  = COORD_MIN + int'($urandom_range(0, (1 << CW) - 1));
               b  = COORD_MIN + int'($urandom_range(0, (1 << CW) - 1));
               rb = (a < b) ? a : b;
               rt = (a < b) ? b : a;
            end
         endcase
         write_edge(REG_LEFT_X, rl);
         write_edge(REG_RIGHT_X, rr);
         write_edge(REG_BOTTOM_Y, rb);
         write_edge(REG_TOP_Y, rt);

         case (p % 4)
            0: begin
               idle_pct  = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct  = 75;
               stall_pct <= 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct <= 75;
            end
            default: begin
               idle_pct  = 33;
               stall_pct <= 33;
            end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            shape = $urandom_range(0, 99);
            sx = pick_coord(rl, rr);
            sy = pick_coord(rb, rt);
            ex = pick_coord(rl, rr);
            ey = pick_coord(rb, rt);
            if (shape < 10) begin
               ex = sx;
            end else if (shape < 20) begin
               ey = sy;
            end else if (shape < 23) begin
               ex = sx;
               ey = sy;
            end else if (shape < 38) begin
               // A segment centered on a corner or an edge point, so the line
               // passes exactly through it.
               px = $urandom_range(0, 1) ? rl : rr;
               py = $urandom_range(0, 1) ? rb : rt;
               if ($urandom_range(0, 1)) begin
                  px = int'(pick_coord(rl, rr));
               end
               dx = int'($urandom_range(0, 1024)) - 512;
               dy = int'($urandom_range(0, 1024)) - 512;
               sx = clamp_coord(px + dx);
               sy = clamp_coord(py + dy);
               ex = clamp_coord(px - dx);
               ey = clamp_coord(py - dy);
            end
            send_segment(sx, sy, ex, ey);
         end
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && hits_outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/segrect_pkg.sv
sv/segment_rectangle_intersection_core.sv
tb/segrect_hit_check.sv
tb/segment_rectangle_intersection_core_tb.sv
